/* rtl/core/mlpf_pkg.sv */
// Shared constants, types and keyword tables of the modem line packet framer.
`default_nettype none

package mlpf_pkg;

    // Line buffer geometry
    localparam int BUFFER_DEPTH = 32;
    localparam int W_IDX        = $clog2(BUFFER_DEPTH);
    localparam int W_CNT        = $clog2(BUFFER_DEPTH + 1);

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_CALL = 2'd2;
    localparam logic [1:0] KIND_REL  = 2'd3;

    // Configuration register indexes
    localparam int         W_CFG_IDX       = 8;
    localparam logic [7:0] CFG_SESSION     = 8'd0;
    localparam logic [7:0] CFG_WAIT_MODE   = 8'd1;
    localparam logic [7:0] CFG_WAIT_CHAR   = 8'd2;
    localparam logic [7:0] CFG_SEPARATOR   = 8'd3;
    localparam logic [7:0] SEPARATOR_RESET = 8'h13;

    localparam logic [7:0] BYTE_CR = 8'h0D;

    // Keyword lengths
    localparam int LEN_CONNECT = 7;
    localparam int LEN_NOCARR  = 10;
    localparam int LEN_BUSY    = 4;

    // Datapath commands from the controller
    typedef struct packed {
        logic       accept;     // store the incoming byte
        logic       idx_clr;    // restart the flush read index
        logic       rd_issue;   // read buffer at the flush index
        logic       emit_echo;  // load echo item into output register
        logic       emit_byte;  // load packet byte into output register
        logic       emit_call;  // load call event into output register
        logic [1:0] flush_kind; // kind of packet bytes being flushed
        logic       clr_fill;   // packet done, buffer empty
    } t_dp_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic out_free;   // output register can take an item this cycle
        logic sess;       // session active
        logic wmode;      // wait-character mode
        logic is_wait;    // last byte equals wait character
        logic is_sep;     // last byte equals separator
        logic is_cr;      // last byte is a carriage return
        logic full;       // buffer holds BUFFER_DEPTH bytes
        logic conn;       // buffer starts with CONNECT
        logic rel;        // buffer starts with NO CARRIER or BUSY
        logic last_idx;   // flush index points at final stored byte
    } t_dp_sts;

    function automatic logic [7:0] kw_connect_at(input logic [W_IDX-1:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (p < W_IDX'(LEN_CONNECT)) begin
            case (p[2:0])
                3'd0:    c = "C";
                3'd1:    c = "O";
                3'd2:    c = "N";
                3'd3:    c = "N";
                3'd4:    c = "E";
                3'd5:    c = "C";
                3'd6:    c = "T";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] kw_nocarr_at(input logic [W_IDX-1:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (p < W_IDX'(LEN_NOCARR)) begin
            case (p[3:0])
                4'd0:    c = "N";
                4'd1:    c = "O";
                4'd2:    c = " ";
                4'd3:    c = "C";
                4'd4:    c = "A";
                4'd5:    c = "R";
                4'd6:    c = "R";
                4'd7:    c = "I";
                4'd8:    c = "E";
                4'd9:    c = "R";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] kw_busy_at(input logic [W_IDX-1:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (p < W_IDX'(LEN_BUSY)) begin
            case (p[1:0])
                2'd0:    c = "B";
                2'd1:    c = "U";
                2'd2:    c = "S";
                2'd3:    c = "Y";
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/modem_line_packet_framer.sv */
// Top level of the modem line packet framer: controller, datapath, config port.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_rx_byte
//  out     | from block| o_out_valid/ i_out_stall| o_kind, o_data_byte, o_last
//  cfg     | to block  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// One byte at a time: the controller accepts a byte in IDLE, then decides on it
// in DECIDE. An echo adds the ECHO state, a call event the CALL state.
// A flush walks the line buffer through its single registered read port,
// reading each stored byte in READ and emitting it in EMIT.
// Output stalls hold the ECHO, EMIT and CALL states; the output register
// holds a finished item while the next one is prepared.
// Synchronous active-low reset empties the buffer, clears the separator flag
// and restores register defaults; buffer contents are not cleared.
`default_nettype none

module modem_line_packet_framer import mlpf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // byte input
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_rx_byte,
    // result output
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic                      o_last,
    // config write
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [W_CFG_IDX-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Config writes are always ready.
    assign o_cfg_ready = 1'b1;

    mlpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mlpf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

/* rtl/core/mlpf_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module mlpf_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  wire logic [P_WIDTH-1:0]         i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic      [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/mlpf_datapath.sv */
// Datapath: config registers, line buffer, fill count, prefix tracking, output register.
`default_nettype none

module mlpf_datapath import mlpf_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic                 i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic                      o_last
);

    logic             r_sess, r_wmode;
    logic [7:0]       r_wait_char, r_sep_code;
    logic [W_CNT-1:0] r_fill, n_fill;
    logic [W_IDX-1:0] r_idx, n_idx;
    logic [7:0]       r_byte;
    logic             r_fc, r_fn, r_fb, n_fc, n_fn, n_fb;
    logic             r_valid, n_valid;
    logic [1:0]       r_kind, n_kind;
    logic [7:0]       r_data, n_data;
    logic             r_last, n_last;
    logic [W_IDX-1:0] w_pos;
    logic [7:0]       w_rd_data;
    logic             w_last_idx;

    assign w_pos = r_fill[W_IDX-1:0];

    mlpf_ram #(
        .P_WIDTH (8),
        .P_DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept),
        .i_wr_addr (w_pos),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess      <= 1'b0;
            r_wmode     <= 1'b0;
            r_wait_char <= 8'h00;
            r_sep_code  <= SEPARATOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SESSION:   r_sess      <= i_cfg_data[0];
                CFG_WAIT_MODE: r_wmode     <= i_cfg_data[0];
                CFG_WAIT_CHAR: r_wait_char <= i_cfg_data;
                CFG_SEPARATOR: r_sep_code  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Prefix flags track keyword match as bytes land; position 0 restarts them.
    always_comb begin
        n_fc = r_fc;
        n_fn = r_fn;
        n_fb = r_fb;
        if (w_pos < W_IDX'(LEN_CONNECT)) begin
            n_fc = ((w_pos == '0) | r_fc) & (i_rx_byte == kw_connect_at(w_pos));
        end
        if (w_pos < W_IDX'(LEN_NOCARR)) begin
            n_fn = ((w_pos == '0) | r_fn) & (i_rx_byte == kw_nocarr_at(w_pos));
        end
        if (w_pos < W_IDX'(LEN_BUSY)) begin
            n_fb = ((w_pos == '0) | r_fb) & (i_rx_byte == kw_busy_at(w_pos));
        end
    end

    assign w_last_idx = (r_idx == W_IDX'(r_fill - W_CNT'(1)));

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.accept) begin
            n_fill = r_fill + W_CNT'(1);
        end else if (i_cmd.clr_fill) begin
            n_fill = '0;
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.emit_byte) begin
            n_idx = r_idx + W_IDX'(1);
        end
    end

    // Output register
    always_comb begin
        n_valid = r_valid & i_out_stall;
        n_kind  = r_kind;
        n_data  = r_data;
        n_last  = r_last;
        if (i_cmd.emit_echo) begin
            n_valid = 1'b1;
            n_kind  = KIND_ECHO;
            n_data  = r_byte;
            n_last  = 1'b1;
        end else if (i_cmd.emit_byte) begin
            n_valid = 1'b1;
            n_kind  = i_cmd.flush_kind;
            n_data  = w_rd_data;
            n_last  = w_last_idx;
        end else if (i_cmd.emit_call) begin
            n_valid = 1'b1;
            n_kind  = KIND_CALL;
            n_data  = 8'h00;
            n_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_fc    <= 1'b0;
            r_fn    <= 1'b0;
            r_fb    <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            if (i_cmd.accept) begin
                r_fc <= n_fc;
                r_fn <= n_fn;
                r_fb <= n_fb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_rx_byte;
        end
        r_kind <= n_kind;
        r_data <= n_data;
        r_last <= n_last;
    end

    always_comb begin
        o_sts.out_free = ~r_valid | ~i_out_stall;
        o_sts.sess     = r_sess;
        o_sts.wmode    = r_wmode;
        o_sts.is_wait  = (r_byte == r_wait_char);
        o_sts.is_sep   = (r_byte == r_sep_code);
        o_sts.is_cr    = (r_byte == BYTE_CR);
        o_sts.full     = (r_fill == W_CNT'(BUFFER_DEPTH));
        o_sts.conn     = r_fc & (r_fill >= W_CNT'(LEN_CONNECT));
        o_sts.rel      = (r_fn & (r_fill >= W_CNT'(LEN_NOCARR)))
                       | (r_fb & (r_fill >= W_CNT'(LEN_BUSY)));
        o_sts.last_idx = w_last_idx;
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data;
    assign o_last      = r_last;

endmodule

`default_nettype wire

/* rtl/core/mlpf_ctrl.sv */
// Controller: input handshake, packet decision and flush sequencing.
`default_nettype none

module mlpf_ctrl import mlpf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_ECHO   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_CALL   = 3'd5;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_DATA = 2'd1;
    localparam logic [1:0] ACT_REL  = 2'd2;
    localparam logic [1:0] ACT_CALL = 2'd3;

    logic [2:0] r_state, n_state;
    logic       r_sep, n_sep;
    logic       r_echo, n_echo;
    logic [1:0] r_act, n_act;
    logic [1:0] w_cls;

    assign w_cls = i_sts.conn ? ACT_CALL : (i_sts.rel ? ACT_REL : ACT_DATA);

    // State that carries out a stored action
    function automatic logic [2:0] act_state(input logic [1:0] a);
        logic [2:0] s;
        case (a)
            ACT_NONE: s = S_IDLE;
            ACT_CALL: s = S_CALL;
            default:  s = S_READ;
        endcase
        return s;
    endfunction

    always_comb begin
        n_state = r_state;
        n_sep   = r_sep;
        n_echo  = r_echo;
        n_act   = r_act;
        o_cmd   = '0;
        o_cmd.flush_kind = (r_act == ACT_REL) ? KIND_REL : KIND_DATA;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.idx_clr = 1'b1;
                n_echo = 1'b0;
                n_act  = ACT_NONE;
                if (r_sep) begin
                    n_sep = 1'b0;
                    n_act = w_cls;
                end else begin
                    n_echo = i_sts.sess;
                    if (i_sts.full) begin
                        n_act = ACT_DATA;
                    end else if (i_sts.sess && i_sts.wmode) begin
                        n_act = i_sts.is_wait ? ACT_DATA : ACT_NONE;
                    end else if (i_sts.is_sep) begin
                        n_sep = 1'b1;
                    end else if (i_sts.is_cr) begin
                        n_act = w_cls;
                    end
                end
                n_state = n_echo ? S_ECHO : act_state(n_act);
            end
            S_ECHO: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_echo = 1'b1;
                    n_state         = act_state(r_act);
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_sts.last_idx) begin
                        o_cmd.clr_fill = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_CALL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_call = 1'b1;
                    o_cmd.clr_fill  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sep   <= 1'b0;
            r_echo  <= 1'b0;
            r_act   <= ACT_NONE;
        end else begin
            r_state <= n_state;
            r_sep   <= n_sep;
            r_echo  <= n_echo;
            r_act   <= n_act;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/core/mlpf_checker.sv */
// Port-level checker for the modem line packet framer, bound to the top level.
`default_nettype none

module mlpf_checker import mlpf_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_last
);

    // One byte in flight: a transfer in is always followed by a busy cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer not followed by stall");

    // Call event is a single item with zero data.
    a_call_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_CALL)) |-> (o_last && (o_data_byte == 8'h00)))
        else $error("call event malformed");

    // An echo is always a one-item result.
    a_echo_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_ECHO)) |-> o_last)
        else $error("echo without last");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_data_byte) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind modem_line_packet_framer mlpf_checker u_mlpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_data_byte (o_data_byte),
    .o_last      (o_last)
);

`default_nettype wire

/* bench/modem_line_packet_framer_tb.sv */
// Self-checking bench for the modem line packet framer: directed cases, then random lines.
`timescale 1ns / 1ps

module modem_line_packet_framer_tb;
    import mlpf_pkg::*;

    // Register indexes the block must ignore
    localparam logic [7:0] CFG_UNUSED_LOW = 8'd4;
    localparam logic [7:0] CFG_UNUSED_TOP = 8'hFF;

    localparam int RANDOM_ITEMS  = 270;
    localparam int SETTLE_CYCLES = 16;   // idle time before register writes
    localparam int DRAIN_CYCLES  = 80;
    localparam int IDLE_LIMIT    = 2000;

    // One result word as the block presents it
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } t_framed_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_rx_byte   = 8'h00;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [W_CFG_IDX-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = 8'h00;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_kind;
    logic [7:0]           o_data_byte;
    logic                 o_last;
    logic                 o_cfg_ready;

    always #1 i_clk = ~i_clk;

    modem_line_packet_framer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the framer: line buffer, separator flag, registers
    // ------------------------------------------------------------------
    logic [7:0]   line_buf [BUFFER_DEPTH];
    int           line_fill     = 0;
    bit           sep_pending   = 1'b0;
    bit           cfg_session   = 1'b0;
    bit           cfg_wait_mode = 1'b0;
    logic [7:0]   cfg_wait_char = 8'h00;
    logic [7:0]   cfg_separator = SEPARATOR_RESET;
    t_framed_item framed_items_due[$];

    // Run bookkeeping
    int gap_max        = 14;
    int stall_max      = 14;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int calls_seen     = 0;
    int release_seen   = 0;
    int register_writes = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    task automatic expect_item(input logic [1:0] kind, input logic [7:0] data,
                               input logic last);
        t_framed_item item;
        item.kind      = kind;
        item.data_byte = data;
        item.last      = last;
        framed_items_due.push_back(item);
    endtask

    // Packet prefix test; bytes never stored are never compared
    function automatic bit starts_with(input string word);
        int i;
        if (line_fill < word.len())
            return 1'b0;
        for (i = 0; i < word.len(); i++)
            if (line_buf[i] != word[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic flush_line(input logic [1:0] kind);
        int i;
        for (i = 0; i < line_fill; i++)
            expect_item(kind, line_buf[i], i == line_fill - 1);
        line_fill = 0;
    endtask

    task automatic classify_line();
        if (starts_with("CONNECT")) begin
            expect_item(KIND_CALL, 8'h00, 1'b1);   // call event drops the bytes
            line_fill = 0;
        end else if (starts_with("NO CARRIER") || starts_with("BUSY")) begin
            flush_line(KIND_REL);
        end else begin
            flush_line(KIND_DATA);
        end
    endtask

    // Everything one received byte makes the framer emit
    task automatic frame_rx_byte(input logic [7:0] b);
        if (line_fill >= BUFFER_DEPTH)
            line_fill = 0;
        line_buf[line_fill] = b;
        line_fill++;
        // code byte after a separator: not echoed, closes in any mode
        if (sep_pending) begin
            sep_pending = 1'b0;
            classify_line();
            return;
        end
        if (cfg_session)
            expect_item(KIND_ECHO, b, 1'b1);
        if (line_fill >= BUFFER_DEPTH) begin
            flush_line(KIND_DATA);
            return;
        end
        // wait mode: besides a full buffer only the wait character closes, never classifies
        if (cfg_session && cfg_wait_mode) begin
            if (b == cfg_wait_char)
                flush_line(KIND_DATA);
            return;
        end
        if (b == cfg_separator)
            sep_pending = 1'b1;
        else if (b == BYTE_CR)
            classify_line();
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: register shadow, prediction on input transfers, check on
    // output transfers. Everything is sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_framed_item want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SESSION:   cfg_session   = i_cfg_data[0];
                    CFG_WAIT_MODE: cfg_wait_mode = i_cfg_data[0];
                    CFG_WAIT_CHAR: cfg_wait_char = i_cfg_data;
                    CFG_SEPARATOR: cfg_separator = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                frame_rx_byte(i_rx_byte);
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (framed_items_due.size() == 0) begin
                    $error("unexpected result: kind %0d data_byte %0h last %0d",
                           o_kind, o_data_byte, o_last);
                    mismatches++;
                end else begin
                    want = framed_items_due.pop_front();
                    if (want.kind == KIND_CALL)
                        calls_seen++;
                    if (want.kind == KIND_REL)
                        release_seen++;
                    compare_field("kind", 8'(want.kind), 8'(o_kind));
                    compare_field("data_byte", want.data_byte, o_data_byte);
                    compare_field("last", 8'(want.last), 8'(o_last));
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Output side: a fresh random hold before every result transfer
    initial begin : out_backpressure
        int hold;
        forever begin
            hold = $urandom_range(0, stall_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $error("no transfer for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Valid is left high after the transfer so back-to-back bytes never
    // lower and raise it in the same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (framed_items_due.size() != 0);
    endtask

    // Idle point for register writes: all results in, last byte decided
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [7:0] idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        register_writes++;
    endtask

    task automatic end_register_writes();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        do
            c = 8'("A" + $urandom_range(0, 25));
        while (c == cfg_separator || c == cfg_wait_char);
        return c;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return BYTE_CR;
            3:       return SEPARATOR_RESET;
            default: return 8'($urandom);
        endcase
    endfunction

    // Picks CR, separator plus code byte, or wait char; whether it closes depends on mode
    task automatic send_terminator();
        int pick;
        pick = $urandom_range(0, 3);
        if (cfg_session && cfg_wait_mode && pick != 0)
            pick = 3;
        case (pick)
            0, 1: send_byte(BYTE_CR);
            2: begin
                send_byte(cfg_separator);
                send_byte(8'($urandom));
            end
            default: send_byte(cfg_wait_char);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: no echo, separator 0x13; a short prefix stays data
    task automatic test_reset_defaults();
        send_text("BUS");
        send_byte(BYTE_CR);
    endtask

    task automatic test_keywords();
        send_text("CONNECT");
        send_byte(BYTE_CR);
        send_text("BUSY");
        send_byte(BYTE_CR);
    endtask

    // A carriage return as the code byte closes the line itself
    task automatic test_separator();
        send_byte(SEPARATOR_RESET);
        send_byte(BYTE_CR);
    endtask

    // Echo on; the code byte after the separator is not echoed
    task automatic test_echo();
        settle();
        write_register(CFG_SESSION, 8'h01);
        end_register_writes();
        send_byte("Z");
        send_byte(SEPARATOR_RESET);
        send_byte(8'h00);
    endtask

    // Wait mode: separator and CR are stored and echoed but do not close the line
    task automatic test_wait_mode();
        settle();
        write_register(CFG_WAIT_MODE, 8'h01);
        write_register(CFG_WAIT_CHAR, 8'hFF);
        end_register_writes();
        send_byte(SEPARATOR_RESET);
        send_byte(BYTE_CR);
        send_byte(8'hFF);
    endtask

    // Upper data bits dropped, unknown indexes ignored
    task automatic test_register_masking();
        settle();
        write_register(CFG_SESSION, 8'hFE);
        write_register(CFG_UNUSED_LOW, 8'h01);
        write_register(CFG_UNUSED_TOP, "Q");
        end_register_writes();
        send_byte("Q");
        send_byte(BYTE_CR);
    endtask

    task automatic test_random_traffic();
        int         phase, first_byte, phase_end, sel, len, fill_now;
        logic [7:0] wchar, sep, filler;
        string      word;
        phase      = 0;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_ITEMS) begin
            // new settings, first two phases at the code extremes
            settle();
            case (phase)
                0:       begin sep = 8'h00; wchar = 8'hFF; end
                1:       begin sep = 8'hFF; wchar = 8'h00; end
                default: begin sep = pick_code(); wchar = pick_code(); end
            endcase
            write_register(CFG_SESSION, 8'($urandom));
            write_register(CFG_WAIT_MODE, 8'($urandom));
            write_register(CFG_WAIT_CHAR, wchar);
            write_register(CFG_SEPARATOR, sep);
            if ($urandom_range(0, 1))
                write_register(8'($urandom_range(4, 255)), 8'($urandom));
            end_register_writes();
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 14;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            phase_end = bytes_sent + $urandom_range(30, 60);

            while (bytes_sent < phase_end) begin
                sel = $urandom_range(0, 15);
                if (sel < 5) begin
                    // keyword line, sometimes cut short, with a tail
                    case ($urandom_range(0, 2))
                        0:       word = "CONNECT";
                        1:       word = "NO CARRIER";
                        default: word = "BUSY";
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        word = word.substr(0, $urandom_range(0, word.len() - 1));
                    send_text(word);
                    repeat ($urandom_range(0, 4)) send_byte(pick_letter());
                    send_terminator();
                end else if (sel < 10) begin
                    repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
                    send_terminator();
                end else if (sel == 10) begin
                    // long line, may run into the full-buffer flush
                    repeat ($urandom_range(25, 40)) send_byte(pick_letter());
                    send_terminator();
                end else if (sel == 11) begin
                    // separator lands as the byte that fills the buffer
                    wait_for_results();
                    filler = pick_letter();
                    if (sep_pending) begin
                        fill_now = 0;
                        send_byte(filler);
                    end else begin
                        fill_now = line_fill;
                    end
                    repeat (BUFFER_DEPTH - 1 - fill_now) send_byte(filler);
                    send_byte(cfg_separator);
                end else if (sel < 15) begin
                    len = $urandom_range(1, 6);
                    repeat (len) send_byte(8'($urandom));
                end else begin
                    wait_for_results();
                end
            end
            phase++;
        end
    endtask

    initial begin : run
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_keywords();
        test_separator();
        test_echo();
        test_wait_mode();
        test_register_masking();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (framed_items_due.size() != 0) begin
            $error("%0d results never arrived", framed_items_due.size());
            mismatches++;
        end

        $display("framed %0d bytes, checked %0d results, %0d register writes",
                 bytes_sent, results_seen, register_writes);
        $display("among them %0d call events and %0d release bytes",
                 calls_seen, release_seen);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* modem_line_packet_framer.f */
rtl/core/mlpf_pkg.sv
rtl/core/mlpf_ram.sv
rtl/core/mlpf_datapath.sv
rtl/core/mlpf_ctrl.sv
rtl/core/modem_line_packet_framer.sv
rtl/core/mlpf_checker.sv
bench/modem_line_packet_framer_tb.sv
